/* rtl/cjt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cjt_pkg: shared types and constants of the coverage join tracker
// Table geometry, field widths, and the structs passed between the control
// logic, the merge logic and the row table.
// ----------------------------------------------------------------------------
package cjt_pkg;

  localparam int ROWS       = 1024;
  localparam int COVER_BITS = 64;

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FIELD_W = 10;   // width of row_base and row_index
  localparam int SUM_W   = 11;   // width of base plus index
  localparam int GEN_W   = 64;
  localparam int MASK_W  = 64;   // width of the contribution and the mask register
  localparam int TALLY_W = 16;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  typedef logic [ROW_W-1:0]      row_addr_t;
  typedef logic [COVER_BITS-1:0] cover_t;

  // one table row: generation tag and coverage bits
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    cover_t           cov;
  } row_entry_t;

  // access request from control to the row table
  typedef struct packed {
    logic       rd_en;
    row_addr_t  rd_addr;
    logic       wr_en;
    row_addr_t  wr_addr;
    row_entry_t wr_data;
  } table_req_t;

  // outcome of merging one contribution into a row
  typedef struct packed {
    row_entry_t entry;
    logic       became_ready;
  } merge_res_t;

endpackage
`default_nettype wire

/* rtl/cjt_feed_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cjt_feed_if: input item channel
// Valid/ready channel carrying one contribution to a table row.
// ----------------------------------------------------------------------------
interface cjt_feed_if;
  import cjt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_W-1:0]     row_base;
  logic [FIELD_W-1:0]     row_index;
  logic [GEN_W-1:0]       gen_tag;
  logic [MASK_W-1:0]      contribution;
  logic                   end_of_batch;

  modport source (
    output valid, row_base, row_index, gen_tag, contribution, end_of_batch,
    input  ready
  );

  modport sink (
    input  valid, row_base, row_index, gen_tag, contribution, end_of_batch,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/cjt_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cjt_result_if: result item channel
// Valid/ready channel carrying the outcome for one row contribution.
// ----------------------------------------------------------------------------
interface cjt_result_if;
  import cjt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SUM_W-1:0]     ready_row;
  logic                 became_ready;
  logic                 out_of_range;
  logic [TALLY_W-1:0]   ready_count;
  logic                 batch_done;

  modport source (
    output valid, ready_row, became_ready, out_of_range, ready_count, batch_done,
    input  ready
  );

  modport sink (
    input  valid, ready_row, became_ready, out_of_range, ready_count, batch_done,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/coverage_join_tracker_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_join_tracker_top: per-row coverage join with generation tags
// Tracks coverage bits per table row and reports when a row becomes complete.
// ----------------------------------------------------------------------------
// Usage:
//   feed   : valid/ready input, one item per row contribution
//            (row_base, row_index, gen_tag, contribution, end_of_batch).
//   result : valid/ready output, exactly one item per input item, in order.
//   cfg_we/cfg_wdata : write the required coverage mask; write only while idle.
// Timing:
//   An accepted item reads its row from the table at the accept edge; the
//   merged row is written back and the result registered at finish, which
//   waits while an earlier result is still held and not taken. A new item is
//   accepted only after the last one is written back, set by the
//   read-then-write sequence on the row table.
// Reset:
//   After rst the table is cleared one row per cycle, all ROWS (1024) rows;
//   feed.ready stays low during that pass. The mask and tally reset to 0.
// Stall:
//   A waiting result is held in the output register while the next item is
//   accepted and read; that item's write-back waits until the result is taken.
// ----------------------------------------------------------------------------
module coverage_join_tracker_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [cjt_pkg::MASK_W-1:0] cfg_wdata,
  cjt_feed_if.sink                       feed,
  cjt_result_if.source                   result
);
  import cjt_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t               state;
  row_addr_t            clr_addr;
  logic [MASK_W-1:0]    required_mask;
  logic [TALLY_W-1:0]   tally;

  // item held between accept and write-back
  logic [SUM_W-1:0]     item_row;
  logic                 item_in_range;
  logic [GEN_W-1:0]     item_gen;
  cover_t               item_contrib;
  logic                 item_eob;

  // output register
  logic                 res_valid;
  logic [SUM_W-1:0]     res_row;
  logic                 res_ready_flag;
  logic                 res_oor;
  logic [TALLY_W-1:0]   res_count;
  logic                 res_eob;

  logic                 accept;
  logic                 finish;
  logic [SUM_W-1:0]     feed_row;
  logic                 feed_in_range;
  table_req_t           tbl_req;
  row_entry_t           tbl_rd;
  merge_res_t           merged;
  logic                 ready_now;
  logic [TALLY_W-1:0]   tally_next;

  assign feed.ready = (state == ST_IDLE);
  assign accept     = feed.valid && feed.ready;
  assign finish     = (state == ST_UPDATE) && (!res_valid || result.ready);

  // row number and range check of the incoming item
  assign feed_row      = {1'b0, feed.row_base} + {1'b0, feed.row_index};
  assign feed_in_range = (32'(feed_row) < 32'(ROWS));

  // table access: clear sweep, read at accept, write-back at finish
  always_comb begin
    tbl_req.rd_en   = accept && feed_in_range;
    tbl_req.rd_addr = ROW_W'(feed_row);
    if (state == ST_CLEAR) begin
      tbl_req.wr_en   = 1'b1;
      tbl_req.wr_addr = clr_addr;
      tbl_req.wr_data = '0;
    end else begin
      tbl_req.wr_en   = finish && item_in_range;
      tbl_req.wr_addr = ROW_W'(item_row);
      tbl_req.wr_data = merged.entry;
    end
  end

  cjt_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  cjt_merge u_merge (
    .stored       (tbl_rd),
    .gen_tag      (item_gen),
    .contribution (item_contrib),
    .required     (required_mask[COVER_BITS-1:0]),
    .res          (merged)
  );

  // advance the saturating batch tally
  assign ready_now  = item_in_range && merged.became_ready;
  assign tally_next = (ready_now && (tally != TALLY_MAX)) ? tally + 1'b1 : tally;

  // hold the required mask
  always_ff @(posedge clk) begin
    if (rst) begin
      required_mask <= '0;
    end else if (cfg_we) begin
      required_mask <= cfg_wdata;
    end
  end

  // sequencer, tally and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      tally     <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == ROW_W'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (finish) begin
            state <= ST_IDLE;
            tally <= item_eob ? '0 : tally_next;
          end
        end
        default: state <= ST_CLEAR;
      endcase

      if (finish) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      item_row      <= feed_row;
      item_in_range <= feed_in_range;
      item_gen      <= feed.gen_tag;
      item_contrib  <= feed.contribution[COVER_BITS-1:0];
      item_eob      <= feed.end_of_batch;
    end
  end

  // load the result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      res_row        <= item_row;
      res_ready_flag <= ready_now;
      res_oor        <= !item_in_range;
      res_count      <= tally_next;
      res_eob        <= item_eob;
    end
  end

  assign result.valid        = res_valid;
  assign result.ready_row    = res_row;
  assign result.became_ready = res_ready_flag;
  assign result.out_of_range = res_oor;
  assign result.ready_count  = res_count;
  assign result.batch_done   = res_eob;

endmodule
`default_nettype wire

/* rtl/cjt_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cjt_table: row table memory
// One write port and one read port, read data registered.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module cjt_table (
  input  wire logic                clk,
  input  wire cjt_pkg::table_req_t req,
  output cjt_pkg::row_entry_t      rd_data
);
  import cjt_pkg::*;

  row_entry_t mem [ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/cjt_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cjt_merge: coverage join of one contribution
// Drops stale coverage on a generation mismatch, ORs in the contribution and
// flags the row when its coverage first equals the required mask exactly.
// ----------------------------------------------------------------------------
module cjt_merge (
  input  wire cjt_pkg::row_entry_t  stored,
  input  wire logic [cjt_pkg::GEN_W-1:0] gen_tag,
  input  wire cjt_pkg::cover_t      contribution,
  input  wire cjt_pkg::cover_t      required,
  output cjt_pkg::merge_res_t  res
);
  import cjt_pkg::*;

  cover_t prev;
  cover_t cov;

  // take stored coverage only when the generation matches
  assign prev = (stored.gen == gen_tag) ? stored.cov : '0;
  assign cov  = prev | contribution;

  assign res.entry.gen    = gen_tag;
  assign res.entry.cov    = cov;
  assign res.became_ready = (cov == required) && (prev != required);

endmodule
`default_nettype wire

/* bench/cjt_join_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cjt_join_monitor: result prediction and comparison for the join tracker
// Watches the feed, result and mask-write ports, keeps its own copy of the
// row table, the batch tally and the required mask, queues the outcome that
// each accepted item should produce and compares every accepted result
// against the oldest queued outcome, field by field.
// ----------------------------------------------------------------------------
module cjt_join_monitor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cjt_pkg::MASK_W-1:0] cfg_wdata,
  cjt_feed_if                        feed,
  cjt_result_if                      result,
  output int                         fail_count,
  output int                         pending,
  output int                         ready_rows,
  output int                         oor_rows,
  output int                         results_seen
);
  import cjt_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]   row;
    logic               became_ready;
    logic               out_of_range;
    logic [TALLY_W-1:0] ready_count;
    logic               batch_done;
  } row_outcome_t;

  logic [GEN_W-1:0]   gen_table [ROWS];
  cover_t             cov_table [ROWS];
  logic [TALLY_W-1:0] batch_tally;
  cover_t             need_mask;
  row_outcome_t       outcome_q [$];
  int                 fails = 0;
  int                 n_ready = 0;
  int                 n_oor = 0;
  int                 n_results = 0;

  // Merge one contribution into the shadow table and return its outcome
  function automatic row_outcome_t join_contribution(
    input logic [FIELD_W-1:0] base,
    input logic [FIELD_W-1:0] index,
    input logic [GEN_W-1:0]   gen,
    input logic [MASK_W-1:0]  contrib,
    input logic               eob
  );
    row_outcome_t     o;
    cover_t           prior;
    cover_t           merged;
    logic [SUM_W-1:0] row;
    row = SUM_W'(base) + SUM_W'(index);
    o = '0;
    o.row = row;
    o.batch_done = eob;
    if (row < ROWS) begin
      // stale generation: stored coverage counts as empty
      prior = (gen_table[row[ROW_W-1:0]] == gen) ? cov_table[row[ROW_W-1:0]] : '0;
      merged = prior | cover_t'(contrib);
      gen_table[row[ROW_W-1:0]] = gen;
      cov_table[row[ROW_W-1:0]] = merged;
      if (merged == need_mask && prior != need_mask) begin
        o.became_ready = 1'b1;
        if (batch_tally != TALLY_MAX) batch_tally++;
      end
    end else begin
      o.out_of_range = 1'b1;
    end
    o.ready_count = batch_tally;
    if (eob) batch_tally = '0;
    return o;
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    fails++;
    if (fails <= 40) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    row_outcome_t want;
    if (rst) begin
      // clear the shadow table along with the block
      for (int r = 0; r < ROWS; r++) begin
        gen_table[r] = '0;
        cov_table[r] = '0;
      end
      batch_tally = '0;
      need_mask = '0;
      outcome_q.delete();
    end else begin
      if (cfg_we) need_mask = cover_t'(cfg_wdata);

      // compare a taken result with the oldest outcome
      if (result.valid && result.ready) begin
        n_results++;
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(result.ready_row), 64'd0);
        end else begin
          want = outcome_q.pop_front();
          if (result.ready_row !== want.row)
            report_mismatch("ready_row", 64'(result.ready_row), 64'(want.row));
          if (result.became_ready !== want.became_ready)
            report_mismatch("became_ready", 64'(result.became_ready), 64'(want.became_ready));
          if (result.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", 64'(result.out_of_range), 64'(want.out_of_range));
          if (result.ready_count !== want.ready_count)
            report_mismatch("ready_count", 64'(result.ready_count), 64'(want.ready_count));
          if (result.batch_done !== want.batch_done)
            report_mismatch("batch_done", 64'(result.batch_done), 64'(want.batch_done));
          if (want.became_ready) n_ready++;
          if (want.out_of_range) n_oor++;
        end
      end

      // predict the outcome of an accepted item
      if (feed.valid && feed.ready) begin
        outcome_q.push_back(join_contribution(feed.row_base, feed.row_index, feed.gen_tag,
                                              feed.contribution, feed.end_of_batch));
      end
    end
    fail_count   <= fails;
    pending      <= outcome_q.size();
    ready_rows   <= n_ready;
    oor_rows     <= n_oor;
    results_seen <= n_results;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the coverage join tracker
// Drives directed items over row extremes, stale and matching generations,
// out-of-range rows and batch ends, then random join sequences under several
// required masks, then a single batch of back-to-back items that, after the
// first, each turn their row ready. Sender bursts and receiver stalls are
// random; a separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import cjt_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 100;
  localparam int SAT_ITEMS   = 40;

  typedef struct {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] index;
    logic [GEN_W-1:0]   gen;
    logic [MASK_W-1:0]  contrib;
    logic               eob;
  } feed_item_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int ready_rows;
  int oor_rows;
  int results_seen;

  int               cycle_count = 0;
  int               burst_left = 0;
  int               items_sent = 0;
  int               settings_used = 0;
  bit               no_gaps = 1'b0;
  logic [7:0]       stall_pat = 8'hFF;
  logic [GEN_W-1:0] gen_pool [4];
  logic [MASK_W-1:0] mask_now = '0;
  feed_item_t       run_a [$];
  feed_item_t       run_b [$];

  cjt_feed_if   feed_ch ();
  cjt_result_if result_ch ();

  coverage_join_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .feed      (feed_ch),
    .result    (result_ch)
  );

  cjt_join_monitor join_monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .feed         (feed_ch),
    .result       (result_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .ready_rows   (ready_rows),
    .oor_rows     (oor_rows),
    .results_seen (results_seen)
  );

  always #4 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: step result ready through an 8-bit ready pattern that is redrawn at random
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    result_ch.ready <= stall_pat[cycle_count % 8];
  end

  // Offer one item, opening a new burst after a random gap when due
  task automatic send_item(input feed_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      if (gap != 0) begin
        feed_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    feed_ch.valid        <= 1'b1;
    feed_ch.row_base     <= it.base;
    feed_ch.row_index    <= it.index;
    feed_ch.gen_tag      <= it.gen;
    feed_ch.contribution <= it.contrib;
    feed_ch.end_of_batch <= it.eob;
    @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain;
    feed_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    mask_now = m;
    settings_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Build an item for a row, with a random split of the row into base and index
  function automatic feed_item_t make_item(input int row, input logic [GEN_W-1:0] gen,
                                           input logic [MASK_W-1:0] contrib);
    feed_item_t it;
    int lo;
    int hi;
    int b;
    lo = (row > 1023) ? row - 1023 : 0;
    hi = (row < 1023) ? row : 1023;
    b = $urandom_range(lo, hi);
    it.base    = FIELD_W'(b);
    it.index   = FIELD_W'(row - b);
    it.gen     = gen;
    it.contrib = contrib;
    it.eob     = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic direct(input int base, input int index, input logic [GEN_W-1:0] gen,
                        input logic [MASK_W-1:0] contrib, input logic eob);
    feed_item_t it;
    it.base    = FIELD_W'(base);
    it.index   = FIELD_W'(index);
    it.gen     = gen;
    it.contrib = contrib;
    it.eob     = eob;
    send_item(it);
  endtask

  // Append contributions that together fill the current mask on one row,
  // sometimes spoiled by an extra bit, a generation change or a repeat
  task automatic build_join(ref feed_item_t seq[$]);
    int               row;
    int               parts;
    int               flavor;
    int               cut;
    logic [GEN_W-1:0] gen;
    logic [MASK_W-1:0] piece [4];
    row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    if ($urandom_range(0, 15) == 0) row = ($urandom_range(0, 1) != 0) ? 1023 : 0;
    gen = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : gen_pool[$urandom_range(0, 3)];
    parts = $urandom_range(1, 4);
    for (int p = 0; p < 4; p++) piece[p] = '0;
    for (int bit_i = 0; bit_i < MASK_W; bit_i++) begin
      if (mask_now[bit_i]) piece[$urandom_range(0, parts - 1)][bit_i] = 1'b1;
    end
    // let some pieces overlap
    if ($urandom_range(0, 1) != 0) begin
      piece[$urandom_range(0, parts - 1)] |= mask_now & {$urandom, $urandom};
    end
    flavor = $urandom_range(0, 5);
    if (flavor == 0) piece[$urandom_range(0, parts - 1)][$urandom_range(0, MASK_W - 1)] = 1'b1;
    cut = (flavor == 1) ? $urandom_range(0, parts - 1) : parts;
    for (int p = 0; p < parts; p++) begin
      if (p == cut) gen = gen_pool[$urandom_range(0, 3)] ^ 64'd1;
      seq.push_back(make_item(row, gen, piece[p]));
    end
    if (flavor == 2) seq.push_back(make_item(row, gen, piece[$urandom_range(0, parts - 1)]));
  endtask

  // One mask setting with random join sequences, interleaved runs and noise
  task automatic run_phase(input logic [MASK_W-1:0] m, input int count);
    int         sent;
    int         kind;
    feed_item_t it;
    drain();
    write_mask(m);
    gen_pool[0] = '0;
    gen_pool[1] = '1;
    gen_pool[2] = {$urandom, $urandom};
    gen_pool[3] = {$urandom, $urandom};
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      run_a.delete();
      run_b.delete();
      if (kind < 6) begin
        build_join(run_a);
      end else if (kind < 8) begin
        build_join(run_a);
        build_join(run_b);
      end else if (kind == 8) begin
        it.base    = FIELD_W'($urandom);
        it.index   = FIELD_W'($urandom);
        it.gen     = {$urandom, $urandom};
        it.contrib = {$urandom, $urandom};
        it.eob     = 1'($urandom);
        run_a.push_back(it);
      end else begin
        run_a.push_back(make_item($urandom_range(ROWS, 2046), {$urandom, $urandom},
                                  {$urandom, $urandom}));
      end
      // alternate two runs so that same-row items are not always adjacent
      while (run_a.size() != 0 || run_b.size() != 0) begin
        if (run_a.size() != 0) begin
          send_item(run_a.pop_front());
          sent++;
        end
        if (run_b.size() != 0) begin
          send_item(run_b.pop_front());
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    feed_ch.valid        <= 1'b0;
    feed_ch.row_base     <= '0;
    feed_ch.row_index    <= '0;
    feed_ch.gen_tag      <= '0;
    feed_ch.contribution <= '0;
    feed_ch.end_of_batch <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset mask of zero: generation zero matches the cleared rows
    direct(0, 0, 64'd0, 64'd0, 1'b0);
    direct(1023, 0, '1, '1, 1'b0);
    direct(512, 512, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0);
    direct(1023, 1023, 64'd0, 64'd0, 1'b1);
    drain();

    // full mask: join two halves, repeat, stale generation, range miss mid batch
    write_mask('1);
    direct(5, 0, 64'h55, 64'h0000_0000_FFFF_FFFF, 1'b0);
    direct(0, 5, 64'h55, 64'hFFFF_FFFF_0000_0000, 1'b0);
    direct(2, 3, 64'h55, '1, 1'b0);
    direct(1000, 100, 64'h55, '1, 1'b0);
    direct(5, 0, 64'h77, '1, 1'b0);
    direct(6, 0, 64'h77, '1, 1'b1);
    direct(6, 0, 64'h77, 64'hFF, 1'b0);
    direct(7, 0, 64'd0, '1, 1'b0);
    direct(600, 600, 64'd0, '1, 1'b1);
    drain();

    // top bit only: an extra bit spoils a ready row
    write_mask(64'h8000_0000_0000_0000);
    direct(0, 0, 64'd0, 64'h8000_0000_0000_0000, 1'b0);
    direct(0, 0, 64'd0, 64'd1, 1'b0);
    direct(0, 0, 64'd5, 64'h8000_0000_0000_0000, 1'b1);
    drain();

    // zero mask written back explicitly
    write_mask('0);
    direct(1023, 0, 64'd0, 64'd0, 1'b0);
    direct(3, 0, 64'd0, 64'h10, 1'b1);

    // random join sequences under several masks
    run_phase('1, PHASE_ITEMS);
    run_phase((64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63)) |
              (64'd1 << $urandom_range(0, 63)), PHASE_ITEMS);
    run_phase({$urandom, $urandom}, PHASE_ITEMS);
    run_phase(64'h8000_0000_0000_0001, PHASE_ITEMS);
    run_phase('0, PHASE_ITEMS);

    // one batch on a single-bit mask: flip the generation so every item after
    // the first turns its row ready and the tally climbs item by item
    drain();
    write_mask(64'd1);
    no_gaps = 1'b1;
    for (int i = 0; i < SAT_ITEMS; i++) begin
      direct(7, 0, {63'd0, 1'(i)}, 64'd1, i == SAT_ITEMS - 1);
    end
    no_gaps = 1'b0;
    drain();

    // allow a stray late result to show up
    repeat (8) @(posedge clk);

    $display("Sent %0d items under %0d mask settings, %0d results checked.",
             items_sent, settings_used, results_seen);
    $display("Rows turned ready: %0d, out-of-range rows: %0d, tally run of %0d items.",
             ready_rows, oor_rows, SAT_ITEMS);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cjt_pkg.sv
rtl/cjt_feed_if.sv
rtl/cjt_result_if.sv
rtl/cjt_table.sv
rtl/cjt_merge.sv
rtl/coverage_join_tracker_top.sv
bench/cjt_join_monitor.sv
bench/testbench.sv
